// ===== rtl/wtvm_pkg.sv =====
// package: register map, field types and frame payload types of the wavetable voice mixer
`default_nettype none
package wtvm_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [15:0] mix_t;
    typedef logic signed [15:0] volume_t;
    typedef logic        [31:0] address_t;
    typedef logic        [15:0] step_t;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_VOLUME_LEFT   = 3'd0;
    localparam reg_idx_t REG_VOLUME_RIGHT  = 3'd1;
    localparam reg_idx_t REG_STEP_WHOLE    = 3'd2;
    localparam reg_idx_t REG_STEP_FRACTION = 3'd3;
    localparam reg_idx_t REG_LOOP_ENABLE   = 3'd4;
    localparam reg_idx_t REG_LOOP_START    = 3'd5;
    localparam reg_idx_t REG_SAMPLE_END    = 3'd6;
    localparam reg_idx_t REG_START_ADDRESS = 3'd7;

    // input frame as held in the input stage
    typedef struct packed {
        sample_t sample_value;
        mix_t    mix_left_in;
        mix_t    mix_right_in;
        logic    first_voice;
    } frame_in_t;

    // result frame as held in the output stage
    typedef struct packed {
        mix_t     mix_left_out;
        mix_t     mix_right_out;
        address_t fetch_address;
        logic     voice_active;
    } frame_out_t;

endpackage
`default_nettype wire

// ===== rtl/wtvm_if.sv =====
// interfaces: input frame channel and result frame channel with valid/ready handshake
`default_nettype none
interface wtvm_in_if;
    import wtvm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_value;
    mix_t    mix_left_in;
    mix_t    mix_right_in;
    logic    first_voice;

    modport source (output valid, output sample_value, output mix_left_in,
                    output mix_right_in, output first_voice, input ready);
    modport sink   (input valid, input sample_value, input mix_left_in,
                    input mix_right_in, input first_voice, output ready);
endinterface

interface wtvm_out_if;
    import wtvm_pkg::*;

    logic     valid;
    logic     ready;
    mix_t     mix_left_out;
    mix_t     mix_right_out;
    address_t fetch_address;
    logic     voice_active;

    modport source (output valid, output mix_left_out, output mix_right_out,
                    output fetch_address, output voice_active, input ready);
    modport sink   (input valid, input mix_left_out, input mix_right_out,
                    input fetch_address, input voice_active, output ready);
endinterface
`default_nettype wire

// ===== rtl/wavetable_voice_mixer.sv =====
// top level: one wavetable playback voice mixed into a stereo frame stream
`default_nettype none
//
// channel   direction  handshake        payload
// in_ch     sink       valid / ready    sample_value, mix_left_in, mix_right_in, first_voice
// out_ch    source     valid / ready    mix_left_out, mix_right_out, fetch_address, voice_active
// apb       slave      psel / penable   paddr[4:2] selects register, pwdata / prdata 32 bits
//
// one frame per clock sustained while out_ch is not stalled; out_ch valid rises once the frame
// has passed the input stage, then the multiply / mix / address update into the output stage
// the phase add and the 32-bit address add and end compare form the loop that sets this rate
// rst_n clears the configuration, the voice position and the playing flag, and both stage valids
// a stalled out_ch holds the output stage; the input stage still takes one more frame
//
module wavetable_voice_mixer (
    input  wire                          clk,
    input  wire                          rst_n,
    wtvm_in_if.sink                      in_ch,
    wtvm_out_if.source                   out_ch,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [wtvm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [wtvm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wtvm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                         pready
);
    import wtvm_pkg::*;

    // configuration registers
    volume_t  volume_left_reg;
    volume_t  volume_right_reg;
    step_t    step_whole_reg;
    step_t    step_fraction_reg;
    logic     loop_enable_reg;
    address_t loop_start_reg;
    address_t sample_end_reg;
    address_t start_address_reg;

    // voice state
    address_t read_position_reg;
    address_t read_position_next;
    step_t    phase_fraction_reg;
    step_t    phase_fraction_next;
    logic     playing_reg;
    logic     playing_next;

    // pipeline stages
    logic       in_valid_reg;
    frame_in_t  in_frame_reg;
    logic       out_valid_reg;
    frame_out_t out_frame_reg;
    frame_out_t out_frame_next;

    logic     cfg_write;
    reg_idx_t cfg_idx;
    logic     out_free;
    logic     stage_move;
    logic     in_take;

    logic signed [31:0] product_left;
    logic signed [31:0] product_right;
    mix_t               contrib_left;
    mix_t               contrib_right;
    logic [16:0]        fraction_sum;
    logic [16:0]        advance;
    address_t           advanced_position;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:2];

    // handshake: output stage frees when empty or being taken
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign stage_move   = in_valid_reg && out_free;
    assign in_ch.ready  = !in_valid_reg || out_free;
    assign in_take      = in_ch.valid && in_ch.ready;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.mix_left_out  = out_frame_reg.mix_left_out;
    assign out_ch.mix_right_out = out_frame_reg.mix_right_out;
    assign out_ch.fetch_address = out_frame_reg.fetch_address;
    assign out_ch.voice_active  = out_frame_reg.voice_active;

    // register read-back
    always_comb
    begin
        case (cfg_idx)
            REG_VOLUME_LEFT:   prdata = {{(CFG_DATA_W-16){volume_left_reg[15]}}, volume_left_reg};
            REG_VOLUME_RIGHT:  prdata = {{(CFG_DATA_W-16){volume_right_reg[15]}},
                                         volume_right_reg};
            REG_STEP_WHOLE:    prdata = {{(CFG_DATA_W-16){1'b0}}, step_whole_reg};
            REG_STEP_FRACTION: prdata = {{(CFG_DATA_W-16){1'b0}}, step_fraction_reg};
            REG_LOOP_ENABLE:   prdata = {{(CFG_DATA_W-1){1'b0}}, loop_enable_reg};
            REG_LOOP_START:    prdata = loop_start_reg;
            REG_SAMPLE_END:    prdata = sample_end_reg;
            REG_START_ADDRESS: prdata = start_address_reg;
            default:           prdata = '0;
        endcase
    end

    // gain products, bits 17..2 kept as the 16-bit contribution
    assign product_left  = volume_left_reg * in_frame_reg.sample_value;
    assign product_right = volume_right_reg * in_frame_reg.sample_value;
    assign contrib_left  = product_left[17:2];
    assign contrib_right = product_right[17:2];

    // phase advance: carry out of the fraction joins the whole step at 17 bits
    assign fraction_sum      = {1'b0, phase_fraction_reg} + {1'b0, step_fraction_reg};
    assign advance           = {1'b0, step_whole_reg} + {16'd0, fraction_sum[16]};
    assign advanced_position = read_position_reg + {15'd0, advance};

    always_comb
    begin
        read_position_next  = read_position_reg;
        phase_fraction_next = phase_fraction_reg;
        playing_next        = playing_reg;
        out_frame_next.mix_left_out  = in_frame_reg.mix_left_in;
        out_frame_next.mix_right_out = in_frame_reg.mix_right_in;

        if (playing_reg)
        begin
            if (in_frame_reg.first_voice)
            begin
                out_frame_next.mix_left_out  = contrib_left;
                out_frame_next.mix_right_out = contrib_right;
            end
            else
            begin
                out_frame_next.mix_left_out  = in_frame_reg.mix_left_in + contrib_left;
                out_frame_next.mix_right_out = in_frame_reg.mix_right_in + contrib_right;
            end

            phase_fraction_next = fraction_sum[15:0];

            // zero advance skips the end test
            if (advance != 17'd0)
            begin
                read_position_next = advanced_position;
                if (advanced_position >= sample_end_reg)
                begin
                    if (loop_enable_reg)
                        read_position_next = loop_start_reg;
                    else
                        playing_next = 1'b0;
                end
            end
        end

        out_frame_next.fetch_address = read_position_next;
        out_frame_next.voice_active  = playing_next;
    end

    // configuration and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_left_reg    <= '0;
            volume_right_reg   <= '0;
            step_whole_reg     <= '0;
            step_fraction_reg  <= '0;
            loop_enable_reg    <= 1'b0;
            loop_start_reg     <= '0;
            sample_end_reg     <= '0;
            start_address_reg  <= '0;
            read_position_reg  <= '0;
            phase_fraction_reg <= '0;
            playing_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_VOLUME_LEFT:   volume_left_reg   <= pwdata[15:0];
                REG_VOLUME_RIGHT:  volume_right_reg  <= pwdata[15:0];
                REG_STEP_WHOLE:    step_whole_reg    <= pwdata[15:0];
                REG_STEP_FRACTION: step_fraction_reg <= pwdata[15:0];
                REG_LOOP_ENABLE:   loop_enable_reg   <= pwdata[0];
                REG_LOOP_START:    loop_start_reg    <= pwdata;
                REG_SAMPLE_END:    sample_end_reg    <= pwdata;
                REG_START_ADDRESS:
                begin
                    // restarts the voice from the new address
                    start_address_reg  <= pwdata;
                    read_position_reg  <= pwdata;
                    phase_fraction_reg <= '0;
                    playing_reg        <= 1'b1;
                end
                default: ;
            endcase
        end
        else if (stage_move)
        begin
            read_position_reg  <= read_position_next;
            phase_fraction_reg <= phase_fraction_next;
            playing_reg        <= playing_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_frame_reg.sample_value <= in_ch.sample_value;
            in_frame_reg.mix_left_in  <= in_ch.mix_left_in;
            in_frame_reg.mix_right_in <= in_ch.mix_right_in;
            in_frame_reg.first_voice  <= in_ch.first_voice;
        end
        if (stage_move)
            out_frame_reg <= out_frame_next;
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: directed table and random frame bursts for the wavetable voice mixer, with scoreboard
module testbench;
    import wtvm_pkg::*;

    // generous bound, far beyond the slowest correct run
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_FRAMES = 400;
    // pipeline is two stages deep, so a few spare cycles are plenty
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_e;

    // one row of the directed table: a register write or a frame transfer
    typedef struct {
        row_kind_e   kind;
        reg_idx_t    idx;
        logic [31:0] value;
        frame_in_t   frame;
        bit          typed;
        frame_out_t  result;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wtvm_in_if  in_ch();
    wtvm_out_if out_ch();

    wavetable_voice_mixer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // voice registers as the block should hold them, reset values
    volume_t  vol_left  = '0;
    volume_t  vol_right = '0;
    step_t    step_int  = '0;
    step_t    step_frac = '0;
    logic     loop_on   = 1'b0;
    address_t loop_addr = '0;
    address_t end_addr  = '0;
    address_t start_reg = '0;

    // playback state of the voice
    address_t    voice_pos   = '0;
    logic [15:0] voice_phase = '0;
    logic        voice_on    = 1'b0;

    // mix frames still owed by the block, oldest first
    frame_out_t mix_expected[$];
    stim_row_t  stim_plan[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    // set for a stretch of the random part: neither side idles
    bit  steady_run  = 1'b0;

    // clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // register write as the block sees it
    function automatic void voice_load_reg(input reg_idx_t idx, input logic [31:0] value);
        case (idx)
            REG_VOLUME_LEFT:   vol_left  = value[15:0];
            REG_VOLUME_RIGHT:  vol_right = value[15:0];
            REG_STEP_WHOLE:    step_int  = value[15:0];
            REG_STEP_FRACTION: step_frac = value[15:0];
            REG_LOOP_ENABLE:   loop_on   = value[0];
            REG_LOOP_START:    loop_addr = value;
            REG_SAMPLE_END:    end_addr  = value;
            REG_START_ADDRESS:
            begin
                // start write restarts the voice from the top
                start_reg   = value;
                voice_pos   = value;
                voice_phase = '0;
                voice_on    = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // mix one frame and move the voice on by one step
    function automatic frame_out_t voice_predict(input frame_in_t f);
        logic signed [31:0] prod_l;
        logic signed [31:0] prod_r;
        logic [15:0]        part_l;
        logic [15:0]        part_r;
        logic [16:0]        fsum;
        logic [16:0]        adv;
        frame_out_t         r;

        r.mix_left_out  = f.mix_left_in;
        r.mix_right_out = f.mix_right_in;
        if (voice_on)
        begin
            prod_l = $signed(vol_left) * $signed(f.sample_value);
            prod_r = $signed(vol_right) * $signed(f.sample_value);
            // contribution is bits 17..2 of the full product
            part_l = prod_l[17:2];
            part_r = prod_r[17:2];
            if (f.first_voice)
            begin
                r.mix_left_out  = part_l;
                r.mix_right_out = part_r;
            end
            else
            begin
                r.mix_left_out  = f.mix_left_in + part_l;
                r.mix_right_out = f.mix_right_in + part_r;
            end
            fsum        = {1'b0, voice_phase} + {1'b0, step_frac};
            voice_phase = fsum[15:0];
            // advance is 17 bits wide: whole step plus fraction carry
            adv = {1'b0, step_int} + {16'b0, fsum[16]};
            if (adv != '0)
            begin
                voice_pos = voice_pos + {15'b0, adv};
                if (voice_pos >= end_addr)
                begin
                    if (loop_on)
                        voice_pos = loop_addr;
                    else
                        voice_on = 1'b0;
                end
            end
        end
        r.fetch_address = voice_pos;
        r.voice_active  = voice_on;
        return r;
    endfunction

    function automatic void plan_write(input reg_idx_t idx, input logic [31:0] value);
        stim_row_t row;
        row.kind   = ROW_WRITE;
        row.idx    = idx;
        row.value  = value;
        row.frame  = '0;
        row.typed  = 1'b0;
        row.result = '0;
        stim_plan.push_back(row);
    endfunction

    function automatic void plan_frame(input sample_t s, input mix_t l, input mix_t r,
                                       input logic fv, input bit typed = 1'b0,
                                       input frame_out_t res = '0);
        stim_row_t row;
        row.kind               = ROW_FRAME;
        row.idx                = REG_VOLUME_LEFT;
        row.value              = '0;
        row.frame.sample_value = s;
        row.frame.mix_left_in  = l;
        row.frame.mix_right_in = r;
        row.frame.first_voice  = fv;
        row.typed              = typed;
        row.result             = res;
        stim_plan.push_back(row);
    endfunction

    function automatic volume_t pick_volume();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return volume_t'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        voice_load_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_frame(input frame_in_t f, input bit typed, input frame_out_t typed_res);
        frame_out_t res;
        while (!steady_run && $urandom_range(99) < 16)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= f.sample_value;
        in_ch.mix_left_in  <= f.mix_left_in;
        in_ch.mix_right_in <= f.mix_right_in;
        in_ch.first_voice  <= f.first_voice;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        // transfer taken at this edge; predictor runs even for typed rows to keep state
        res = voice_predict(f);
        if (typed)
            res = typed_res;
        mix_expected.push_back(res);
    endtask

    // let the pipeline empty before touching the registers
    task automatic settle_voice();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (mix_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random back-pressure, changed at the falling edge
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= steady_run || ($urandom_range(99) >= 16);
        end
    end

    // scoreboard: every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        frame_out_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (mix_expected.size() == 0)
                flag_mismatch("result transfer with nothing expected");
            else
            begin
                want = mix_expected.pop_front();
                if (out_ch.mix_left_out !== want.mix_left_out)
                    flag_mismatch($sformatf("mix_left_out %h, want %h",
                                            out_ch.mix_left_out, want.mix_left_out));
                if (out_ch.mix_right_out !== want.mix_right_out)
                    flag_mismatch($sformatf("mix_right_out %h, want %h",
                                            out_ch.mix_right_out, want.mix_right_out));
                if (out_ch.fetch_address !== want.fetch_address)
                    flag_mismatch($sformatf("fetch_address %h, want %h",
                                            out_ch.fetch_address, want.fetch_address));
                if (out_ch.voice_active !== want.voice_active)
                    flag_mismatch($sformatf("voice_active %b, want %b",
                                            out_ch.voice_active, want.voice_active));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("wavetable_voice_mixer test failed");
            $finish;
        end
    end

    initial
    begin
        frame_in_t   f;
        bit          need_settle;
        bit          long_done;
        int          random_sent;
        int          burst;
        address_t    base;
        address_t    start_a;
        address_t    end_a;
        address_t    loop_a;
        int unsigned span;
        step_t       whole;
        step_t       frac;

        need_settle = 1'b0;
        long_done   = 1'b0;
        random_sent = 0;

        // all inputs known from time zero, reset held low at the start
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample_value = '0;
        in_ch.mix_left_in  = '0;
        in_ch.mix_right_in = '0;
        in_ch.first_voice  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle voice after reset: mix passes straight through, first_voice ignored
        plan_frame(16'h7fff, 16'h1234, 16'h8000, 1'b1, 1'b1,
                   frame_out_t'{16'h1234, 16'h8000, 32'h0000_0000, 1'b0});

        // top gains of both signs, half-step fraction, stop at the end without loop
        plan_write(REG_VOLUME_LEFT, 32'h0000_7fff);
        plan_write(REG_VOLUME_RIGHT, 32'h0000_8000);
        plan_write(REG_STEP_WHOLE, 32'h0000_0001);
        plan_write(REG_STEP_FRACTION, 32'h0000_8000);
        plan_write(REG_LOOP_ENABLE, 32'h0000_0000);
        plan_write(REG_LOOP_START, 32'h0000_0010);
        plan_write(REG_SAMPLE_END, 32'h0000_0020);
        plan_write(REG_START_ADDRESS, 32'h0000_001e);
        plan_frame(16'h7fff, 16'h0000, 16'h0000, 1'b0);
        plan_frame(16'h8000, 16'h7fff, 16'h8000, 1'b0);
        // voice stopped in the frame before, position kept past the end
        plan_frame(16'h1111, 16'h5555, 16'haaaa, 1'b0, 1'b1,
                   frame_out_t'{16'h5555, 16'haaaa, 32'h0000_0021, 1'b0});

        // most negative gain, whole step at its top plus carry, address wrap, loop
        plan_write(REG_VOLUME_LEFT, 32'h0000_8000);
        plan_write(REG_VOLUME_RIGHT, 32'h0000_ffff);
        plan_write(REG_LOOP_ENABLE, 32'h0000_0001);
        plan_write(REG_STEP_WHOLE, 32'h0000_ffff);
        plan_write(REG_STEP_FRACTION, 32'h0000_ffff);
        plan_write(REG_LOOP_START, 32'h0000_0100);
        plan_write(REG_SAMPLE_END, 32'h0002_0000);
        plan_write(REG_START_ADDRESS, 32'hffff_fff0);
        plan_frame(16'h8000, 16'h0000, 16'h0000, 1'b1);
        plan_frame(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        plan_frame(16'h0000, 16'h8000, 16'hffff, 1'b1);

        // loop start lying past the end is taken as it is
        plan_write(REG_LOOP_START, 32'hffff_0000);
        plan_frame(16'h4000, 16'h1234, 16'hedcb, 1'b0);
        plan_frame(16'hc000, 16'hffff, 16'h0001, 1'b1);
        plan_frame(16'h0001, 16'h8000, 16'h7fff, 1'b0);

        // zero advance: address stays put and the end test is skipped
        plan_write(REG_SAMPLE_END, 32'h0000_0000);
        plan_write(REG_STEP_WHOLE, 32'h0000_0000);
        plan_write(REG_STEP_FRACTION, 32'h0000_0000);
        plan_write(REG_START_ADDRESS, 32'h0000_0005);
        plan_frame(16'h1234, 16'h0001, 16'h0002, 1'b0);

        // fraction alone carries every fourth frame, then loops
        plan_write(REG_STEP_FRACTION, 32'h0000_4000);
        plan_write(REG_LOOP_START, 32'h0000_0003);
        plan_frame(16'h5a5a, 16'h0f0f, 16'hf0f0, 1'b0);
        plan_frame(16'ha5a5, 16'hf0f0, 16'h0f0f, 1'b1);
        plan_frame(16'h0101, 16'h7f00, 16'h00ff, 1'b0);
        plan_frame(16'hfefe, 16'h80ff, 16'hff00, 1'b0);

        // address wrap with no loop, mix wrap at both ends, then stop on the end
        plan_write(REG_LOOP_ENABLE, 32'h0000_0000);
        plan_write(REG_VOLUME_LEFT, 32'h0000_7fff);
        plan_write(REG_VOLUME_RIGHT, 32'h0000_7fff);
        plan_write(REG_STEP_WHOLE, 32'h0000_0002);
        plan_write(REG_STEP_FRACTION, 32'h0000_0000);
        plan_write(REG_SAMPLE_END, 32'hffff_ffff);
        plan_write(REG_START_ADDRESS, 32'hffff_fffe);
        plan_frame(16'h7fff, 16'h7fff, 16'h8000, 1'b0);
        plan_frame(16'h8000, 16'h8000, 16'h7fff, 1'b0);
        plan_write(REG_SAMPLE_END, 32'h0000_0004);
        plan_frame(16'h2222, 16'h0000, 16'h0000, 1'b1);
        plan_frame(16'hffff, 16'h0000, 16'hffff, 1'b1, 1'b1,
                   frame_out_t'{16'h0000, 16'hffff, 32'h0000_0004, 1'b0});

        // walk the table; registers are only written once the pipeline is empty
        foreach (stim_plan[i])
        begin
            if (stim_plan[i].kind == ROW_WRITE)
            begin
                if (need_settle)
                    settle_voice();
                need_settle = 1'b0;
                cfg_write(stim_plan[i].idx, stim_plan[i].value);
            end
            else
            begin
                send_frame(stim_plan[i].frame, stim_plan[i].typed, stim_plan[i].result);
                need_settle = 1'b1;
            end
        end

        // random part: each phase sets up a fresh voice, then a burst of frames
        while (random_sent < RANDOM_FRAMES)
        begin
            settle_voice();

            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: whole = step_t'($urandom_range(3));
                6:                whole = 16'h0000;
                7:                whole = 16'hffff;
                default:          whole = step_t'($urandom);
            endcase
            case ($urandom_range(9))
                0:       frac = 16'h0000;
                1:       frac = 16'hffff;
                default: frac = step_t'($urandom);
            endcase

            // mostly a sample window the voice can play through, sometimes anything
            if ($urandom_range(3) == 0)
            begin
                start_a = $urandom;
                end_a   = $urandom;
                loop_a  = $urandom;
            end
            else
            begin
                base    = $urandom;
                span    = $urandom_range(1, 600);
                start_a = base;
                end_a   = base + span;
                if ($urandom_range(4) == 0)
                    loop_a = $urandom;
                else
                    loop_a = base + $urandom_range(span);
            end

            cfg_write(REG_VOLUME_LEFT, {16'h0000, pick_volume()});
            cfg_write(REG_VOLUME_RIGHT, {16'h0000, pick_volume()});
            cfg_write(REG_STEP_WHOLE, {16'h0000, whole});
            cfg_write(REG_STEP_FRACTION, {16'h0000, frac});
            cfg_write(REG_LOOP_ENABLE, {31'b0, 1'($urandom_range(1))});
            cfg_write(REG_LOOP_START, loop_a);
            cfg_write(REG_SAMPLE_END, end_a);
            // now and then the voice is left as it was, often stopped
            if ($urandom_range(99) < 85)
                cfg_write(REG_START_ADDRESS, start_a);

            // one long burst with no idling on either side, short random bursts otherwise
            if (!long_done && random_sent >= 150)
            begin
                burst      = 100;
                long_done  = 1'b1;
                steady_run = 1'b1;
            end
            else
                burst = $urandom_range(4, 30);
            repeat (burst)
            begin
                f.sample_value     = sample_t'($urandom);
                f.mix_left_in      = mix_t'($urandom);
                f.mix_right_in     = mix_t'($urandom);
                f.first_voice      = 1'($urandom_range(1));
                send_frame(f, 1'b0, '0);
                random_sent++;
            end
            steady_run = 1'b0;
        end

        // drain, then a few spare cycles for any stray transfer
        settle_voice();
        if (mismatches == 0)
            $display("wavetable_voice_mixer test passed");
        else
            $display("wavetable_voice_mixer test failed");
        $finish;
    end

endmodule

// ===== wavetable_voice_mixer.f =====
rtl/wtvm_pkg.sv
rtl/wtvm_if.sv
rtl/wavetable_voice_mixer.sv
tb/testbench.sv
